>>> design/ecef_to_radar_spherical_defines.svh
// Assertion macros for the checker file of this block.
`ifndef ECEF_TO_RADAR_SPHERICAL_DEFINES_SVH
`define ECEF_TO_RADAR_SPHERICAL_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define E2RS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define E2RS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/e2rs_pkg.sv
package e2rs_pkg;

  // Default field widths.
  localparam int COORD_BITS_DEF = 34;
  localparam int ANGLE_BITS_DEF = 16;

  // Fixed widths of the trigonometric and radius registers.
  localparam int TRIG_W   = 32;
  localparam int RADIUS_W = 34;

  // Total pipeline depth from input request to output register.
  localparam int LAT = 154;

  // Reset value of the effective earth radius in mm.
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 34'd8500000000;
  localparam logic [TRIG_W-1:0]   ONE_Q30      = 32'h4000_0000;

  // Register indexes of the configuration port.
  typedef enum logic [2:0] {
    REG_RADAR_X,
    REG_RADAR_Y,
    REG_RADAR_Z,
    REG_SIN_LAT,
    REG_COS_LAT,
    REG_SIN_LON,
    REG_COS_LON,
    REG_EARTH_RADIUS
  } cfg_reg_t;

  // Arctangent of 2^-i in units of 2^-32 turn.
  function automatic logic [31:0] atan_turn(input int unsigned i);
    case (i)
      0:  return 32'h20000000;
      1:  return 32'h12E4051E;
      2:  return 32'h09FB385B;
      3:  return 32'h051111D4;
      4:  return 32'h028B0D43;
      5:  return 32'h0145D7E1;
      6:  return 32'h00A2F61E;
      7:  return 32'h00517C55;
      8:  return 32'h0028BE53;
      9:  return 32'h00145F2F;
      10: return 32'h000A2F98;
      11: return 32'h000517CC;
      12: return 32'h00028BE6;
      13: return 32'h000145F3;
      14: return 32'h0000A2FA;
      15: return 32'h0000517D;
      16: return 32'h000028BE;
      17: return 32'h0000145F;
      18: return 32'h00000A30;
      19: return 32'h00000518;
      20: return 32'h0000028C;
      21: return 32'h00000146;
      22: return 32'h000000A3;
      23: return 32'h00000051;
      24: return 32'h00000029;
      25: return 32'h00000014;
      26: return 32'h0000000A;
      27: return 32'h00000005;
      28: return 32'h00000003;
      29: return 32'h00000001;
      30: return 32'h00000001;
      default: return 32'h00000000;
    endcase
  endfunction

  // Round a Q30 sum to whole mm: add one half, then floor.
  function automatic logic signed [63:0] rnd_q30(input logic signed [127:0] s);
    logic [127:0] t;
    t = s + 128'd536870912;
    return signed'(t[93:30]);
  endfunction

endpackage

>>> design/e2rs_delay.sv
module e2rs_delay import e2rs_pkg::*; #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sr [0:N-1];

  // Shift line that advances with the pipeline.
  always_ff @(posedge clk) begin
    if (en) begin
      sr[0] <= d;
      for (int i = 1; i < N; i++) begin
        sr[i] <= sr[i-1];
      end
    end
  end

  assign q = sr[N-1];

endmodule

>>> design/e2rs_mul.sv
module e2rs_mul import e2rs_pkg::*; (
  input  logic                clk,
  input  logic                en,
  input  logic signed [63:0]  a,
  input  logic signed [63:0]  b,
  output logic signed [127:0] p
);

  logic [63:0]  am, bm;
  logic         neg0, neg1, neg2;
  logic [63:0]  p00, p01, p10, p11;
  logic [127:0] sum;

  // Four stages: magnitudes, 32 by 32 partial products, sum, sign.
  always_ff @(posedge clk) begin
    if (en) begin
      am   <= a[63] ? 64'(-a) : 64'(a);
      bm   <= b[63] ? 64'(-b) : 64'(b);
      neg0 <= a[63] ^ b[63];
      p00  <= am[31:0] * bm[31:0];
      p01  <= am[31:0] * bm[63:32];
      p10  <= am[63:32] * bm[31:0];
      p11  <= am[63:32] * bm[63:32];
      neg1 <= neg0;
      sum  <= {64'd0, p00} + ({64'd0, p01} << 32) + ({64'd0, p10} << 32)
              + {p11, 64'd0};
      neg2 <= neg1;
      p    <= neg2 ? signed'(-sum) : signed'(sum);
    end
  end

endmodule

>>> design/e2rs_sqrt.sv
module e2rs_sqrt import e2rs_pkg::*; (
  input  logic         clk,
  input  logic         en,
  input  logic [127:0] n,
  output logic [63:0]  root
);

  logic [65:0]  rem [1:64];
  logic [63:0]  rt  [1:64];
  logic [127:0] nn  [1:64];

  // One result bit per stage, two radicand bits consumed each time.
  for (genvar g = 0; g < 64; g++) begin : g_stage
    logic [65:0]  rem_i;
    logic [63:0]  rt_i;
    logic [127:0] nn_i;
    logic [67:0]  r2, trial;
    logic         ge;
    if (g == 0) begin : g_first
      assign rem_i = '0;
      assign rt_i  = '0;
      assign nn_i  = n;
    end else begin : g_next
      assign rem_i = rem[g];
      assign rt_i  = rt[g];
      assign nn_i  = nn[g];
    end
    assign r2    = {rem_i, nn_i[127:126]};
    assign trial = {2'b00, rt_i, 2'b01};
    assign ge    = (r2 >= trial);
    always_ff @(posedge clk) begin
      if (en) begin
        rem[g+1] <= ge ? 66'(r2 - trial) : r2[65:0];
        rt[g+1]  <= {rt_i[62:0], ge};
        nn[g+1]  <= {nn_i[125:0], 2'b00};
      end
    end
  end

  assign root = rt[64];

endmodule

>>> design/e2rs_div.sv
module e2rs_div import e2rs_pkg::*; (
  input  logic         clk,
  input  logic         en,
  input  logic [127:0] n,
  input  logic [34:0]  d,
  output logic [62:0]  q
);

  localparam logic [62:0] CAP = 63'd1 << 62;

  logic [34:0] rem [0:63];
  logic [62:0] qb  [0:63];
  logic [62:0] nb  [0:63];
  logic        ovf [0:63];

  // Entry stage: a quotient of 2^63 or more is flagged here; the output saturates at 2^62.
  always_ff @(posedge clk) begin
    if (en) begin
      ovf[0] <= (n[127:63] >= {30'd0, d});
      rem[0] <= n[97:63];
      qb[0]  <= '0;
      nb[0]  <= n[62:0];
    end
  end

  // Restoring division, one quotient bit per stage.
  for (genvar g = 1; g < 64; g++) begin : g_stage
    logic [35:0] r2;
    logic        ge;
    assign r2 = {rem[g-1], nb[g-1][62]};
    assign ge = (r2 >= {1'b0, d});
    always_ff @(posedge clk) begin
      if (en) begin
        rem[g] <= ge ? 35'(r2 - {1'b0, d}) : r2[34:0];
        qb[g]  <= {qb[g-1][61:0], ge};
        nb[g]  <= {nb[g-1][61:0], 1'b0};
        ovf[g] <= ovf[g-1];
      end
    end
  end

  assign q = (ovf[63] || qb[63] > CAP) ? CAP : qb[63];

endmodule

>>> design/e2rs_cordic.sv
module e2rs_cordic import e2rs_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic signed [63:0] x,
  input  logic signed [63:0] y,
  output logic [31:0]        z
);

  logic [63:0]        na  [0:11];
  logic [63:0]        nb  [0:11];
  logic               nyn [0:11];
  logic [31:0]        nz  [0:11];
  logic signed [44:0] cx  [0:32];
  logic signed [44:0] cy  [0:32];
  logic [31:0]        cz  [0:32];

  // Fold the left half plane onto the right one and take magnitudes.
  always_ff @(posedge clk) begin
    if (en) begin
      na[0]  <= x[63] ? 64'(-x) : 64'(x);
      nb[0]  <= y[63] ? 64'(-y) : 64'(y);
      nyn[0] <= x[63] ? (y > 0) : y[63];
      nz[0]  <= x[63] ? 32'h8000_0000 : 32'h0;
    end
  end

  // Normalize the larger magnitude into [2^40, 2^41), right then left.
  for (genvar j = 1; j < 12; j++) begin : g_norm
    logic [63:0] m;
    logic        sh;
    assign m = na[j-1] | nb[j-1];
    if (j < 6) begin : g_right
      localparam int K = 16 >> (j - 1);
      assign sh = |m[63:40+K];
      always_ff @(posedge clk) begin
        if (en) begin
          na[j] <= sh ? (na[j-1] >> K) : na[j-1];
          nb[j] <= sh ? (nb[j-1] >> K) : nb[j-1];
        end
      end
    end else begin : g_left
      localparam int K = 32 >> (j - 6);
      assign sh = ~|m[63:41-K];
      always_ff @(posedge clk) begin
        if (en) begin
          na[j] <= sh ? (na[j-1] << K) : na[j-1];
          nb[j] <= sh ? (nb[j-1] << K) : nb[j-1];
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        nyn[j] <= nyn[j-1];
        nz[j]  <= nz[j-1];
      end
    end
  end

  // Restore the sign of y on the normalized vector.
  always_ff @(posedge clk) begin
    if (en) begin
      cx[0] <= signed'({1'b0, na[11][43:0]});
      cy[0] <= nyn[11] ? signed'(-{1'b0, nb[11][43:0]}) : signed'({1'b0, nb[11][43:0]});
      cz[0] <= nz[11];
    end
  end

  // Vectoring iterations, one per stage.
  for (genvar i = 0; i < 32; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (en) begin
        if (cy[i] > 0) begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          cz[i+1] <= cz[i] + atan_turn(i);
        end else begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          cz[i+1] <= cz[i] - atan_turn(i);
        end
      end
    end
  end

  assign z = cz[32];

endmodule

>>> design/ecef_to_radar_spherical.sv
// Throughput: one request per cycle while the output is not stalled; the
// depth is set by two chained 64-stage square roots (height, then slant
// range) with their multipliers.
// A stalled output holds the whole pipeline in place.
// Reset clears all valid bits and loads the register defaults.
module ecef_to_radar_spherical import e2rs_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] target_x,
  input  logic signed [COORD_BITS-1:0] target_y,
  input  logic signed [COORD_BITS-1:0] target_z,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS:0]   tangent_u,
  output logic signed [COORD_BITS:0]   tangent_v,
  output logic signed [COORD_BITS:0]   height,
  output logic [COORD_BITS:0]          slant_range,
  output logic [ANGLE_BITS-1:0]        azimuth,
  output logic signed [ANGLE_BITS-1:0] elevation,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [5:0]                   paddr,
  input  logic [63:0]                  pwdata,
  output logic [63:0]                  prdata,
  output logic                         pready
);

  localparam int OUT_W = COORD_BITS + 1;
  localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (OUT_W - 1)) - 64'sd1;
  localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;
  localparam logic [63:0] R_MAX = (64'd1 << OUT_W) - 64'd1;
  localparam logic [32:0] HALF = 33'd1 << (31 - ANGLE_BITS);
  localparam logic signed [32:0] QUARTER = 33'sd1 <<< (ANGLE_BITS - 2);
  localparam logic signed [32:0] QUARTER_N = -QUARTER;

  // Configuration registers.
  logic signed [COORD_BITS-1:0] radar_x, radar_y, radar_z;
  logic signed [TRIG_W-1:0]     sin_lat, cos_lat, sin_lon, cos_lon;
  logic [RADIUS_W-1:0]          earth_radius;
  logic [RADIUS_W-1:0]          rad_eff;
  logic                         cfg_wr;
  cfg_reg_t                     cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = cfg_reg_t'(paddr[5:3]);

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      radar_x      <= '0;
      radar_y      <= '0;
      radar_z      <= '0;
      sin_lat      <= '0;
      cos_lat      <= ONE_Q30;
      sin_lon      <= '0;
      cos_lon      <= ONE_Q30;
      earth_radius <= RADIUS_RESET;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_RADAR_X:      radar_x      <= pwdata[COORD_BITS-1:0];
        REG_RADAR_Y:      radar_y      <= pwdata[COORD_BITS-1:0];
        REG_RADAR_Z:      radar_z      <= pwdata[COORD_BITS-1:0];
        REG_SIN_LAT:      sin_lat      <= pwdata[TRIG_W-1:0];
        REG_COS_LAT:      cos_lat      <= pwdata[TRIG_W-1:0];
        REG_SIN_LON:      sin_lon      <= pwdata[TRIG_W-1:0];
        REG_COS_LON:      cos_lon      <= pwdata[TRIG_W-1:0];
        REG_EARTH_RADIUS: earth_radius <= pwdata[RADIUS_W-1:0];
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    case (cfg_sel)
      REG_RADAR_X:      prdata = 64'({1'b0, radar_x});
      REG_RADAR_Y:      prdata = 64'({1'b0, radar_y});
      REG_RADAR_Z:      prdata = 64'({1'b0, radar_z});
      REG_SIN_LAT:      prdata = 64'({1'b0, sin_lat});
      REG_COS_LAT:      prdata = 64'({1'b0, cos_lat});
      REG_SIN_LON:      prdata = 64'({1'b0, sin_lon});
      REG_COS_LON:      prdata = 64'({1'b0, cos_lon});
      REG_EARTH_RADIUS: prdata = 64'(earth_radius);
      default:          prdata = '0;
    endcase
  end

  // A zero radius is taken as one millimeter.
  assign rad_eff = (earth_radius == '0) ? RADIUS_W'(1) : earth_radius;

  // Pipeline advance and valid bits.
  logic [LAT-1:0] vld;
  logic           adv;

  assign adv       = !vld[LAT-1] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  function automatic logic [OUT_W-1:0] sat_out(input logic signed [63:0] v);
    if (v > SAT_HI) return SAT_HI[OUT_W-1:0];
    if (v < SAT_LO) return SAT_LO[OUT_W-1:0];
    return v[OUT_W-1:0];
  endfunction

  // Offsets from the radar.
  logic signed [63:0] dx, dy, dz;

  always_ff @(posedge clk) begin
    if (adv) begin
      dx <= 64'(target_x) - 64'(radar_x);
      dy <= 64'(target_y) - 64'(radar_y);
      dz <= 64'(target_z) - 64'(radar_z);
    end
  end

  // First rotation, about the longitude.
  logic signed [127:0] p_dycl, p_dxsl, p_dxcl, p_dysl;
  logic signed [63:0]  u_r, e_r;

  e2rs_mul u_m_dycl (.clk, .en(adv), .a(dy), .b(64'(cos_lon)), .p(p_dycl));
  e2rs_mul u_m_dxsl (.clk, .en(adv), .a(dx), .b(64'(sin_lon)), .p(p_dxsl));
  e2rs_mul u_m_dxcl (.clk, .en(adv), .a(dx), .b(64'(cos_lon)), .p(p_dxcl));
  e2rs_mul u_m_dysl (.clk, .en(adv), .a(dy), .b(64'(sin_lon)), .p(p_dysl));

  always_ff @(posedge clk) begin
    if (adv) begin
      u_r <= rnd_q30(p_dycl - p_dxsl);
      e_r <= rnd_q30(p_dxcl + p_dysl);
    end
  end

  // Second rotation, about the latitude.
  logic [63:0]         dz5_q, u11_q;
  logic signed [63:0]  dz5, u11;
  logic signed [127:0] p_dzcb, p_esb, p_ecb, p_dzsb;
  logic signed [63:0]  v_r, w_r;

  e2rs_delay #(.W(64), .N(5)) u_d_dz (.clk, .en(adv), .d(dz), .q(dz5_q));
  e2rs_delay #(.W(64), .N(5)) u_d_u (.clk, .en(adv), .d(u_r), .q(u11_q));
  assign dz5 = signed'(dz5_q);
  assign u11 = signed'(u11_q);

  e2rs_mul u_m_dzcb (.clk, .en(adv), .a(dz5), .b(64'(cos_lat)), .p(p_dzcb));
  e2rs_mul u_m_esb  (.clk, .en(adv), .a(e_r), .b(64'(sin_lat)), .p(p_esb));
  e2rs_mul u_m_ecb  (.clk, .en(adv), .a(e_r), .b(64'(cos_lat)), .p(p_ecb));
  e2rs_mul u_m_dzsb (.clk, .en(adv), .a(dz5), .b(64'(sin_lat)), .p(p_dzsb));

  always_ff @(posedge clk) begin
    if (adv) begin
      v_r <= rnd_q30(p_dzcb - p_esb);
      w_r <= rnd_q30(p_ecb + p_dzsb);
    end
  end

  // Radius offset, saturated tangent outputs and the azimuth zero case.
  logic signed [63:0] u12, v12, rw;
  logic [OUT_W-1:0]   su, sv;
  logic               azz;

  always_ff @(posedge clk) begin
    if (adv) begin
      u12 <= u11;
      v12 <= v_r;
      rw  <= 64'(rad_eff) + w_r;
      su  <= sat_out(u11);
      sv  <= sat_out(v_r);
      azz <= (u11 == 64'sd0) && (v_r == 64'sd0);
    end
  end

  // Azimuth angle.
  logic [31:0]           az_z;
  logic                  azz_d;
  logic [32:0]           az_sum;
  logic [ANGLE_BITS-1:0] az_r;

  e2rs_cordic u_cordic_az (.clk, .en(adv), .x(u11), .y(v_r), .z(az_z));
  e2rs_delay #(.W(1), .N(44)) u_d_azz (.clk, .en(adv), .d(azz), .q(azz_d));
  assign az_sum = {1'b0, az_z} + HALF;

  always_ff @(posedge clk) begin
    if (adv) begin
      az_r <= azz_d ? '0 : az_sum[31:32-ANGLE_BITS];
    end
  end

  // Squares of the horizontal distance and of the radial term.
  logic signed [127:0] uu, vv, rw2;
  logic [127:0]        p2a, rw2a, n1, p2b;
  logic                p2z;

  e2rs_mul u_m_uu (.clk, .en(adv), .a(u12), .b(u12), .p(uu));
  e2rs_mul u_m_vv (.clk, .en(adv), .a(v12), .b(v12), .p(vv));
  e2rs_mul u_m_rw (.clk, .en(adv), .a(rw), .b(rw), .p(rw2));

  always_ff @(posedge clk) begin
    if (adv) begin
      p2a  <= uu + vv;
      rw2a <= rw2;
      n1   <= p2a + rw2a;
      p2b  <= p2a;
      p2z  <= (p2a == '0);
    end
  end

  // Square roots and the curvature term.
  logic [63:0] s_root, pr_root;
  logic [62:0] dh_q;

  e2rs_sqrt u_sqrt_s  (.clk, .en(adv), .n(n1), .root(s_root));
  e2rs_sqrt u_sqrt_pr (.clk, .en(adv), .n(p2b), .root(pr_root));
  e2rs_div  u_div_dh  (.clk, .en(adv), .n(p2b), .d({rad_eff, 1'b0}), .q(dh_q));

  // Height, then the vertical offset h - dh.
  logic signed [63:0] h_r, nd;
  logic [62:0]        dh1;
  logic [63:0]        pr1, pr2;
  logic               p2z_d, ezero;
  logic [OUT_W-1:0]   hs;

  e2rs_delay #(.W(1), .N(65)) u_d_p2z (.clk, .en(adv), .d(p2z), .q(p2z_d));

  always_ff @(posedge clk) begin
    if (adv) begin
      h_r   <= signed'(s_root) - 64'(rad_eff);
      dh1   <= dh_q;
      pr1   <= pr_root;
      nd    <= h_r - signed'(64'(dh1));
      ezero <= p2z_d && (h_r == signed'(64'(dh1)));
      hs    <= sat_out(h_r);
      pr2   <= pr1;
    end
  end

  // Slant range.
  logic signed [127:0] nd2;
  logic [127:0]        p2_d, n2;
  logic [63:0]         r_root;

  e2rs_mul u_m_nd (.clk, .en(adv), .a(nd), .b(nd), .p(nd2));
  e2rs_delay #(.W(128), .N(70)) u_d_p2 (.clk, .en(adv), .d(p2b), .q(p2_d));

  always_ff @(posedge clk) begin
    if (adv) begin
      n2 <= p2_d + nd2;
    end
  end

  e2rs_sqrt u_sqrt_r (.clk, .en(adv), .n(n2), .root(r_root));

  // Elevation angle with its zero case and quarter-turn clamp.
  logic [31:0]                 el_z;
  logic                        ezero_d;
  logic signed [32:0]          el_sum, el_sh;
  logic signed [ANGLE_BITS-1:0] el_r;

  e2rs_cordic u_cordic_el (.clk, .en(adv), .x(signed'(pr2)), .y(nd), .z(el_z));
  e2rs_delay #(.W(1), .N(45)) u_d_ez (.clk, .en(adv), .d(ezero), .q(ezero_d));
  assign el_sum = signed'({el_z[31], el_z}) + signed'(HALF);
  assign el_sh  = el_sum >>> (32 - ANGLE_BITS);

  always_ff @(posedge clk) begin
    if (adv) begin
      if (ezero_d) begin
        el_r <= '0;
      end else if (el_sh > QUARTER) begin
        el_r <= QUARTER[ANGLE_BITS-1:0];
      end else if (el_sh < QUARTER_N) begin
        el_r <= QUARTER_N[ANGLE_BITS-1:0];
      end else begin
        el_r <= el_sh[ANGLE_BITS-1:0];
      end
    end
  end

  // Align all results with the slant range.
  logic [OUT_W-1:0]      su_d, sv_d, hs_d;
  logic [ANGLE_BITS-1:0] az_d, el_d;

  e2rs_delay #(.W(OUT_W), .N(141)) u_d_su (.clk, .en(adv), .d(su), .q(su_d));
  e2rs_delay #(.W(OUT_W), .N(141)) u_d_sv (.clk, .en(adv), .d(sv), .q(sv_d));
  e2rs_delay #(.W(OUT_W), .N(69)) u_d_hs (.clk, .en(adv), .d(hs), .q(hs_d));
  e2rs_delay #(.W(ANGLE_BITS), .N(96)) u_d_az (.clk, .en(adv), .d(az_r), .q(az_d));
  e2rs_delay #(.W(ANGLE_BITS), .N(23)) u_d_el (.clk, .en(adv), .d(el_r), .q(el_d));

  // Output register.
  always_ff @(posedge clk) begin
    if (adv) begin
      tangent_u   <= signed'(su_d);
      tangent_v   <= signed'(sv_d);
      height      <= signed'(hs_d);
      slant_range <= (r_root > R_MAX) ? R_MAX[OUT_W-1:0] : r_root[OUT_W-1:0];
      azimuth     <= az_d;
      elevation   <= signed'(el_d);
    end
  end

endmodule

>>> design/e2rs_checker.sv
`include "ecef_to_radar_spherical_defines.svh"

module e2rs_checker import e2rs_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic signed [ANGLE_BITS-1:0] elevation
);

  localparam logic signed [ANGLE_BITS:0] QUARTER = (ANGLE_BITS + 1)'(1) <<< (ANGLE_BITS - 2);

  // A waiting result stays offered.
  `E2RS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result request dropped")

  // A stalled output stops new input requests.
  `E2RS_ASSERT_IMP(a_stall_in, out_valid && !out_ready, !in_ready, "input taken during stall")

  // Nothing comes out right after reset.
  `E2RS_ASSERT_IMP(a_rst_empty, $past(rst), !out_valid, "result after reset")

  // Elevation stays within a quarter turn.
  `E2RS_ASSERT_IMP(a_elev_range, out_valid, (elevation <= QUARTER) && (elevation >= -QUARTER), "elevation out of range")

endmodule

bind ecef_to_radar_spherical e2rs_checker #(.ANGLE_BITS(ANGLE_BITS)) u_e2rs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .elevation (elevation)
);
